// File: hw/rtl/rpfr_pkg.sv
// Shared types, constants and microcode ROM for the rational polynomial fit block.
`default_nettype none

package rpfr_pkg;

    localparam int NREG     = 8;
    localparam int CW       = 32;
    localparam int ADDR_W   = 5;
    localparam int SUM_W    = 52;
    localparam int STEP_W   = 5;
    localparam int CNT_W    = 5;

    localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FIT  = 5'd16;
    localparam logic [CNT_W-1:0]  DIV_LAST  = 5'd31;

    typedef logic [NREG-1:0][CW-1:0] coef_bank_t;

    // multiplier operation
    typedef enum logic [2:0] {M_NONE, M_POW, M_NUM, M_DEN, M_SQ} mop_t;
    // use of the previous product
    typedef enum logic [1:0] {A_NONE, A_PWR, A_NADD, A_DADD} aop_t;
    // other datapath work
    typedef enum logic [2:0] {D_NONE, D_ABS, D_CHECK, D_DIV, D_FIT, D_RES, D_OUT} dop_t;
    // sequencing
    typedef enum logic [2:0] {Q_WAIT_IN, Q_NEXT, Q_SKIP, Q_LOOP, Q_WAIT_OUT} qop_t;

    typedef struct packed {
        mop_t              mop;
        logic [1:0]        midx;
        aop_t              aop;
        logic [1:0]        aidx;
        dop_t              dop;
        qop_t              qop;
        logic [STEP_W-1:0] tgt;
    } uword_t;

    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            5'd0:  w = uword_t'{M_NONE, 2'd0, A_NONE, 2'd0, D_NONE,  Q_WAIT_IN,  STEP_IDLE};
            5'd1:  w = uword_t'{M_POW,  2'd0, A_NONE, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd2:  w = uword_t'{M_NUM,  2'd0, A_PWR,  2'd1, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd3:  w = uword_t'{M_POW,  2'd1, A_NADD, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd4:  w = uword_t'{M_NUM,  2'd1, A_PWR,  2'd2, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd5:  w = uword_t'{M_POW,  2'd2, A_NADD, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd6:  w = uword_t'{M_NUM,  2'd2, A_PWR,  2'd3, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd7:  w = uword_t'{M_NUM,  2'd3, A_NADD, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd8:  w = uword_t'{M_DEN,  2'd0, A_NADD, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd9:  w = uword_t'{M_DEN,  2'd1, A_DADD, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd10: w = uword_t'{M_DEN,  2'd2, A_DADD, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd11: w = uword_t'{M_DEN,  2'd3, A_DADD, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd12: w = uword_t'{M_NONE, 2'd0, A_DADD, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd13: w = uword_t'{M_NONE, 2'd0, A_NONE, 2'd0, D_ABS,   Q_NEXT,     STEP_IDLE};
            5'd14: w = uword_t'{M_NONE, 2'd0, A_NONE, 2'd0, D_CHECK, Q_SKIP,     STEP_FIT};
            5'd15: w = uword_t'{M_NONE, 2'd0, A_NONE, 2'd0, D_DIV,   Q_LOOP,     STEP_IDLE};
            5'd16: w = uword_t'{M_NONE, 2'd0, A_NONE, 2'd0, D_FIT,   Q_NEXT,     STEP_IDLE};
            5'd17: w = uword_t'{M_NONE, 2'd0, A_NONE, 2'd0, D_RES,   Q_NEXT,     STEP_IDLE};
            5'd18: w = uword_t'{M_SQ,   2'd0, A_NONE, 2'd0, D_NONE,  Q_NEXT,     STEP_IDLE};
            5'd19: w = uword_t'{M_NONE, 2'd0, A_NONE, 2'd0, D_OUT,   Q_WAIT_OUT, STEP_IDLE};
            default: w = uword_t'{M_NONE, 2'd0, A_NONE, 2'd0, D_NONE, Q_WAIT_OUT, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rpfr_regs.sv
// APB coefficient register bank for the rational polynomial fit block.
`default_nettype none

module rpfr_regs
    import rpfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CW-1:0]     pwdata,
    output logic      [CW-1:0]     prdata,
    output logic                   pready,
    output coef_bank_t             coef
);

    coef_bank_t     coef_reg;
    logic [2:0]     reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = coef_reg[reg_idx];
    assign coef    = coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            coef_reg[reg_idx] <= pwdata;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rational_poly_fit_residual.sv
// An accepted input word runs through the microcode steps to its result word in the output register;
// a zero denominator or an out-of-range quotient skips the divide.
// Most of the sequence is the bit-serial divider loop over the 32-bit quotient.
// The shared 33x33 multiplier runs the power, term and square steps in sequence.
// The next input is taken while the previous result still waits on the output side.
// Reset (aresetn low, synchronous) clears coefficients, the running sum and the sequencer.
`default_nettype none

module rational_poly_fit_residual
    import rpfr_pkg::*;
#(
    parameter int NUM_TERMS = 4,
    parameter int DEN_TERMS = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // theta[15:0], target[47:16]
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [127:0]      m_tdata,   // fit_value[31:0], residual[63:32], cost_sum[127:64]
    output logic                   m_tuser,   // div_fault
    output logic                   m_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CW-1:0]     pwdata,
    output logic      [CW-1:0]     prdata,
    output logic                   pready
);

    localparam logic signed [CW-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] S_MIN = 32'sh8000_0000;

    coef_bank_t coef;

    rpfr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // sequencer
    logic [STEP_W-1:0]       step_reg, step_next;
    uword_t                  uw;
    logic                    s_accept;
    logic                    out_free;

    // datapath
    logic [15:0]             theta_reg;
    logic signed [CW-1:0]    target_reg;
    logic                    last_reg;
    logic [3:0][15:0]        pw_reg;
    logic signed [SUM_W-1:0] num_reg, den_reg;
    logic signed [65:0]      prod_reg;
    logic [SUM_W-1:0]        an_reg, ad_reg, rem_reg;
    logic                    neg_reg, num_neg_reg, fault_reg, ovf_reg;
    logic [31:0]             dvd_reg, quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [CW-1:0]    fit_reg, res_reg;
    logic [63:0]             acc_reg;

    logic                    m_valid_reg;
    logic [CW-1:0]           m_fit_reg, m_res_reg;
    logic [63:0]             m_cost_reg;
    logic                    m_fault_reg, m_last_reg;

    logic [1:0]              pw_idx;
    logic [16:0]             p_val;
    logic [2:0]              coef_idx;
    logic signed [CW-1:0]    coef_val;
    logic                    term_on;
    logic signed [32:0]      mul_a, mul_b;
    logic                    ovf_c;
    logic [SUM_W:0]          trial, trial_diff;
    logic                    trial_ge;
    logic [32:0]             mag;
    logic signed [CW-1:0]    fit_c, res_c;
    logic signed [32:0]      diff33;
    logic [64:0]             sum65;
    logic [63:0]             cost_c;

    assign uw       = ucode(step_reg);
    assign s_tready = aresetn && (uw.qop == Q_WAIT_IN);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        unique case (uw.qop)
            Q_WAIT_IN:  step_next = s_accept ? step_reg + 1'b1 : step_reg;
            Q_NEXT:     step_next = step_reg + 1'b1;
            Q_SKIP:     step_next = (fault_reg || ovf_c) ? uw.tgt : step_reg + 1'b1;
            Q_LOOP:     step_next = (cnt_reg == DIV_LAST) ? step_reg + 1'b1 : step_reg;
            Q_WAIT_OUT: step_next = out_free ? uw.tgt : step_reg;
            default:    step_next = STEP_IDLE;
        endcase
    end

    // multiplier operands
    always_comb begin
        pw_idx   = (uw.mop == M_NUM) ? uw.midx - 2'd1 : uw.midx;
        p_val    = (uw.mop == M_NUM && uw.midx == 2'd0) ? 17'h1_0000 : {1'b0, pw_reg[pw_idx]};
        coef_idx = {(uw.mop == M_DEN), uw.midx};
        coef_val = $signed(coef[coef_idx]);
        term_on  = (uw.mop == M_DEN) ? (int'(uw.midx) < DEN_TERMS)
                                     : (int'(uw.midx) < NUM_TERMS);
        mul_a    = '0;
        mul_b    = '0;
        case (uw.mop)
            M_POW: begin
                mul_a = $signed({16'b0, p_val});
                mul_b = $signed({17'b0, theta_reg});
            end
            M_NUM, M_DEN: begin
                mul_a = term_on ? {coef_val[CW-1], coef_val} : 33'sd0;
                mul_b = $signed({16'b0, p_val});
            end
            M_SQ: begin
                mul_a = {res_reg[CW-1], res_reg};
                mul_b = {res_reg[CW-1], res_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider, fit and residual arithmetic
    always_comb begin
        ovf_c      = {16'b0, an_reg} >= {ad_reg, 16'b0};
        trial      = {rem_reg, dvd_reg[31]};
        trial_ge   = trial >= {1'b0, ad_reg};
        trial_diff = trial - {1'b0, ad_reg};
        mag        = ovf_reg ? 33'h1_0000_0000 : {1'b0, quo_reg};
        if (fault_reg) begin
            fit_c = num_neg_reg ? S_MIN : S_MAX;
        end else if (neg_reg) begin
            fit_c = (mag >= 33'h0_8000_0000) ? S_MIN : $signed(~mag[31:0] + 32'd1);
        end else begin
            fit_c = (mag > 33'h0_7FFF_FFFF) ? S_MAX : $signed(mag[31:0]);
        end
        diff33 = {fit_reg[CW-1], fit_reg} - {target_reg[CW-1], target_reg};
        if (diff33[32] != diff33[31]) begin
            res_c = diff33[32] ? S_MIN : S_MAX;
        end else begin
            res_c = diff33[31:0];
        end
        sum65  = {1'b0, acc_reg} + {1'b0, prod_reg[63:0]};
        cost_c = sum65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum65[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end else begin
            step_reg <= step_next;
            if (uw.dop == D_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                acc_reg     <= last_reg ? 64'd0 : cost_c;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        // product holds while the output step waits
        if (uw.mop != M_NONE) begin
            prod_reg <= mul_a * mul_b;
        end

        if (s_accept) begin
            theta_reg  <= s_tdata[15:0];
            target_reg <= $signed(s_tdata[47:16]);
            last_reg   <= s_tlast;
            pw_reg[0]  <= s_tdata[15:0];
            num_reg    <= '0;
            den_reg    <= 52'sh1_0000_0000;
        end

        case (uw.aop)
            A_PWR:   pw_reg[uw.aidx] <= prod_reg[31:16];
            A_NADD:  num_reg <= num_reg + prod_reg[SUM_W-1:0];
            A_DADD:  den_reg <= den_reg + prod_reg[SUM_W-1:0];
            default: ;
        endcase

        case (uw.dop)
            D_ABS: begin
                an_reg      <= num_reg[SUM_W-1] ? SUM_W'(-num_reg) : SUM_W'(num_reg);
                ad_reg      <= den_reg[SUM_W-1] ? SUM_W'(-den_reg) : SUM_W'(den_reg);
                neg_reg     <= num_reg[SUM_W-1] ^ den_reg[SUM_W-1];
                num_neg_reg <= num_reg[SUM_W-1];
                fault_reg   <= (den_reg == '0);
            end
            D_CHECK: begin
                ovf_reg <= ovf_c;
                rem_reg <= {16'b0, an_reg[SUM_W-1:16]};
                dvd_reg <= {an_reg[15:0], 16'b0};
                cnt_reg <= '0;
            end
            D_DIV: begin
                rem_reg <= trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
                quo_reg <= {quo_reg[30:0], trial_ge};
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            D_FIT: fit_reg <= fit_c;
            D_RES: res_reg <= res_c;
            D_OUT: begin
                if (out_free) begin
                    m_fit_reg   <= fit_reg;
                    m_res_reg   <= res_reg;
                    m_cost_reg  <= cost_c;
                    m_fault_reg <= fault_reg;
                    m_last_reg  <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_cost_reg, m_res_reg, m_fit_reg};
    assign m_tuser  = m_fault_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
